// ----- hdl/sprite_scanline_evaluation_macros.svh -----
// ============================================================================
// sprite_scanline_evaluation_macros
// Assertion macros shared by the sprite scanline evaluation block.
// ============================================================================
`ifndef SPRITE_SCANLINE_EVALUATION_MACROS_SVH
`define SPRITE_SCANLINE_EVALUATION_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define SSE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("sse assertion failed");

// condition that must never hold outside reset
`define SSE_ASSERT_NEVER(label, clk, rst_n, expr) \
  `SSE_ASSERT(label, clk, rst_n, !(expr))

`else

`define SSE_ASSERT(label, clk, rst_n, prop)
`define SSE_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ----- hdl/sse_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sse_pkg
// Types and constants of the sprite scanline evaluation block.
// ============================================================================
package sse_pkg;

  localparam int BYTE_W   = 8;
  localparam int LANES    = 4;
  localparam int RAM_DEPTH = 256 / LANES;
  localparam int ADDR_W   = $clog2(RAM_DEPTH);
  localparam int NUM_W    = 6;
  localparam int CNT_W    = 7;
  localparam int LINE_W   = 9;

  localparam logic [LINE_W-1:0] PRERENDER_LINE = 9'd261;
  localparam logic [BYTE_W-1:0] FILL_BYTE      = 8'hFF;
  localparam logic [9:0]        HEIGHT_TALL    = 10'd16;
  localparam logic [9:0]        HEIGHT_SHORT   = 10'd8;

  localparam logic [1:0] CFG_TALL      = 2'd0;
  localparam logic [1:0] CFG_RENDERING = 2'd1;
  localparam logic [1:0] CFG_LIMIT     = 2'd2;

  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_EVAL  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_OUT,
    ST_EV_ADDR,
    ST_EV_CHECK,
    ST_EV_FLUSH
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [BYTE_W-1:0] value;
    logic [LINE_W-1:0] line;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              sprite_valid;
    logic [NUM_W-1:0]  sprite_number;
    logic [BYTE_W-1:0] sprite_ypos;
    logic [BYTE_W-1:0] sprite_tile;
    logic [BYTE_W-1:0] sprite_attr;
    logic [BYTE_W-1:0] sprite_xpos;
    logic              overflow;
    logic              zero_in_range;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [1:0] index;
    logic       data;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [BYTE_W-1:0] ypos;
    logic [BYTE_W-1:0] tile;
    logic [BYTE_W-1:0] attr;
    logic [BYTE_W-1:0] xpos;
  } sprite_t;

  typedef struct packed {
    logic clr_wr;
    logic take_set;
    logic take_write;
    logic start_eval;
    logic sel_ptr;
    logic load_read;
    logic mark;
    logic emit;
    logic advance;
    logic load_final;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_range;
    logic stop;
    logic pend_valid;
    logic last_idx;
    logic res_free;
  } status_t;

endpackage

// ----- hdl/sse_chan_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sse_chan_if
// Valid/ready channel carrying one word of a given payload type.
// ============================================================================
interface sse_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/sse_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sse_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
module sse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sse_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sse_ctrl
// Controller: sequences clearing, pointer access, reads and line evaluation.
// ============================================================================
module sse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  sse_pkg::func_e   item_func_i,
  output logic             item_ready_o,
  input  sse_pkg::status_t status_i,
  output sse_pkg::cmd_t    cmd_o
);

  sse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sse_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sse_pkg::ST_CLEAR: begin
        if (status_i.clr_done) state_d = sse_pkg::ST_IDLE;
      end
      sse_pkg::ST_IDLE: begin
        if (item_valid_i && item_func_i == sse_pkg::FUNC_READ) begin
          state_d = sse_pkg::ST_RD_OUT;
        end else if (item_valid_i && item_func_i == sse_pkg::FUNC_EVAL) begin
          state_d = sse_pkg::ST_EV_ADDR;
        end
      end
      sse_pkg::ST_RD_OUT: begin
        if (status_i.res_free) state_d = sse_pkg::ST_IDLE;
      end
      sse_pkg::ST_EV_ADDR: begin
        state_d = sse_pkg::ST_EV_CHECK;
      end
      sse_pkg::ST_EV_CHECK: begin
        if (status_i.in_range && status_i.stop) begin
          state_d = sse_pkg::ST_EV_FLUSH;
        end else if (status_i.in_range && status_i.pend_valid && !status_i.res_free) begin
          state_d = sse_pkg::ST_EV_CHECK;
        end else if (status_i.last_idx) begin
          state_d = sse_pkg::ST_EV_FLUSH;
        end else begin
          state_d = sse_pkg::ST_EV_ADDR;
        end
      end
      sse_pkg::ST_EV_FLUSH: begin
        if (status_i.res_free) state_d = sse_pkg::ST_IDLE;
      end
      default: state_d = sse_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    item_ready_o = 1'b0;
    unique case (state_q)
      sse_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      sse_pkg::ST_IDLE: begin
        item_ready_o     = 1'b1;
        cmd_o.sel_ptr    = 1'b1;
        cmd_o.take_set   = item_valid_i && item_func_i == sse_pkg::FUNC_SET;
        cmd_o.take_write = item_valid_i && item_func_i == sse_pkg::FUNC_WRITE;
        cmd_o.start_eval = item_valid_i && item_func_i == sse_pkg::FUNC_EVAL;
      end
      sse_pkg::ST_RD_OUT: begin
        cmd_o.sel_ptr   = 1'b1;
        cmd_o.load_read = status_i.res_free;
      end
      sse_pkg::ST_EV_ADDR: begin
        cmd_o.sel_ptr = 1'b0;
      end
      sse_pkg::ST_EV_CHECK: begin
        if (status_i.in_range) begin
          cmd_o.mark = 1'b1;
          if (!status_i.stop && (!status_i.pend_valid || status_i.res_free)) begin
            cmd_o.emit    = 1'b1;
            cmd_o.advance = !status_i.last_idx;
          end
        end else begin
          cmd_o.advance = !status_i.last_idx;
        end
      end
      sse_pkg::ST_EV_FLUSH: begin
        cmd_o.load_final = status_i.res_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hdl/sse_dpath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sse_dpath
// Datapath: sprite memory lanes, pointer, range check, pending sprite and
// output register.
// ============================================================================
module sse_dpath #(
  parameter int SPRITE_COUNT = 64,
  parameter int LINE_LIMIT   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sse_pkg::cmd_t    cmd_i,
  output sse_pkg::status_t status_o,
  input  sse_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  sse_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sse_pkg::result_t res_o
);

  logic                              tall_q, rend_q, limen_q;
  logic [sse_pkg::BYTE_W-1:0]        ptr_q;
  logic [sse_pkg::ADDR_W-1:0]        clr_q;
  logic [sse_pkg::NUM_W-1:0]         idx_q;
  logic [sse_pkg::CNT_W-1:0]         cnt_q;
  logic [9:0]                        line_q;
  logic                              ovf_q, zero_q, pend_valid_q, res_valid_q;
  sse_pkg::sprite_t                  pend_q, spr;
  sse_pkg::result_t                  res_q, res_d;

  logic [sse_pkg::LANES-1:0]         ram_we;
  logic [sse_pkg::ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [sse_pkg::BYTE_W-1:0]        ram_wdata;
  logic [sse_pkg::BYTE_W-1:0]        ram_rdata [sse_pkg::LANES];

  logic [10:0]                       diff;
  logic                              in_range, at_limit, res_load;

  // sprite memory, one lane per byte of a sprite
  for (genvar g = 0; g < sse_pkg::LANES; g++) begin : g_lane
    sse_ram #(
      .WIDTH (sse_pkg::BYTE_W),
      .DEPTH (sse_pkg::RAM_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .raddr_i (ram_raddr),
      .rdata_o (ram_rdata[g])
    );
  end

  always_comb begin
    ram_we    = '0;
    ram_waddr = ptr_q[sse_pkg::BYTE_W-1:2];
    ram_wdata = item_i.value;
    if (cmd_i.clr_wr) begin
      ram_we    = '1;
      ram_waddr = clr_q;
      ram_wdata = sse_pkg::FILL_BYTE;
    end else if (cmd_i.take_write) begin
      ram_we[ptr_q[1:0]] = 1'b1;
    end
  end

  assign ram_raddr = cmd_i.sel_ptr ? ptr_q[sse_pkg::BYTE_W-1:2] : idx_q;

  // range check on the signed difference line - y
  assign diff     = {line_q[9], line_q} - {3'b000, ram_rdata[0]};
  assign in_range = !diff[10] && (diff[9:0] < (tall_q ? sse_pkg::HEIGHT_TALL
                                                       : sse_pkg::HEIGHT_SHORT));
  assign at_limit = cnt_q == sse_pkg::CNT_W'(LINE_LIMIT);

  assign spr.number = idx_q;
  assign spr.ypos   = ram_rdata[0];
  assign spr.tile   = ram_rdata[1];
  assign spr.attr   = ram_rdata[2];
  assign spr.xpos   = ram_rdata[3];

  assign res_load = cmd_i.load_read | (cmd_i.emit & pend_valid_q) | cmd_i.load_final;

  always_comb begin
    res_d = '0;
    priority if (cmd_i.load_read) begin
      res_d.read_data = ram_rdata[ptr_q[1:0]];
      res_d.last      = 1'b1;
    end else if (cmd_i.load_final) begin
      if (pend_valid_q) begin
        res_d.sprite_valid  = 1'b1;
        res_d.sprite_number = pend_q.number;
        res_d.sprite_ypos   = pend_q.ypos;
        res_d.sprite_tile   = pend_q.tile;
        res_d.sprite_attr   = pend_q.attr;
        res_d.sprite_xpos   = pend_q.xpos;
      end
      res_d.overflow      = ovf_q;
      res_d.zero_in_range = zero_q;
      res_d.last          = 1'b1;
    end else begin
      res_d.sprite_valid  = 1'b1;
      res_d.sprite_number = pend_q.number;
      res_d.sprite_ypos   = pend_q.ypos;
      res_d.sprite_tile   = pend_q.tile;
      res_d.sprite_attr   = pend_q.attr;
      res_d.sprite_xpos   = pend_q.xpos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tall_q       <= 1'b0;
      rend_q       <= 1'b0;
      limen_q      <= 1'b1;
      ptr_q        <= '0;
      clr_q        <= '0;
      idx_q        <= '0;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      zero_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_i.index)
          sse_pkg::CFG_TALL:      tall_q  <= cfg_i.data;
          sse_pkg::CFG_RENDERING: rend_q  <= cfg_i.data;
          sse_pkg::CFG_LIMIT:     limen_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (cmd_i.take_set) begin
        ptr_q <= item_i.value;
      end else if (cmd_i.take_write) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.start_eval) begin
        idx_q        <= '0;
        cnt_q        <= '0;
        ovf_q        <= 1'b0;
        zero_q       <= 1'b0;
        pend_valid_q <= 1'b0;
      end else begin
        if (cmd_i.advance) idx_q <= idx_q + 1'b1;
        if (cmd_i.mark) begin
          ovf_q  <= ovf_q | (at_limit & rend_q);
          zero_q <= zero_q | (idx_q == '0);
        end
        if (cmd_i.emit) begin
          cnt_q        <= cnt_q + 1'b1;
          pend_valid_q <= 1'b1;
        end else if (cmd_i.load_final) begin
          pend_valid_q <= 1'b0;
        end
      end
      res_valid_q <= res_load | (res_valid_q & ~res_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_eval) begin
      line_q <= (item_i.line == sse_pkg::PRERENDER_LINE) ? '1 : {1'b0, item_i.line};
    end
    if (cmd_i.emit) begin
      pend_q <= spr;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign status_o.clr_done   = clr_q == '1;
  assign status_o.in_range   = in_range;
  assign status_o.stop       = at_limit & limen_q;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.last_idx   = idx_q == sse_pkg::NUM_W'(SPRITE_COUNT - 1);
  assign status_o.res_free   = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/sprite_scanline_evaluation.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sprite_scanline_evaluation
// Sprite attribute memory with pointer access and per-line sprite evaluation.
//
//   port      dir   word
//   item_i    in    func, value, line
//   result_o  out   read_data, sprite fields, overflow, zero_in_range, last
//   cfg_i     in    index, data (tall, rendering, limit)
//
// set pointer and write byte are taken in idle, read byte waits in ST_RD_OUT for a free output
// evaluate passes ST_EV_ADDR, then ST_EV_CHECK for each sprite scanned and ends in ST_EV_FLUSH;
// each sprite takes one registered read of the four memory lanes
// after reset a clearing pass fills the memory with 0xff, no item taken
// a stalled result holds the scan only when another sprite must be sent
// ============================================================================
`include "sprite_scanline_evaluation_macros.svh"

module sprite_scanline_evaluation #(
  parameter int SPRITE_COUNT = 64,
  parameter int LINE_LIMIT   = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  sse_chan_if.sink   item_i,
  sse_chan_if.source result_o,
  sse_chan_if.sink   cfg_i
);

  sse_pkg::cmd_t    cmd;
  sse_pkg::status_t status;
  logic             item_ready;
  logic             res_valid;
  sse_pkg::result_t res_word;

  sse_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_func_i  (item_i.payload.func),
    .item_ready_o (item_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  sse_dpath #(
    .SPRITE_COUNT (SPRITE_COUNT),
    .LINE_LIMIT   (LINE_LIMIT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .item_i      (item_i.payload),
    .cfg_we_i    (cfg_i.valid),
    .cfg_i       (cfg_i.payload),
    .res_valid_o (res_valid),
    .res_ready_i (result_o.ready),
    .res_o       (res_word)
  );

  assign item_i.ready     = item_ready;
  assign cfg_i.ready      = 1'b1;
  assign result_o.valid   = res_valid;
  assign result_o.payload = res_word;

  // only the last word of an item may lack a sprite
  `SSE_ASSERT(a_mid_has_sprite, clk_i, rst_ni, result_o.valid && !result_o.payload.last |-> result_o.payload.sprite_valid)
  // flags travel on the last word only
  `SSE_ASSERT(a_mid_no_flags, clk_i, rst_ni, result_o.valid && !result_o.payload.last |-> !result_o.payload.overflow && !result_o.payload.zero_in_range)
  // scan push and final word never load the output register together
  `SSE_ASSERT_NEVER(a_emit_final, clk_i, rst_ni, cmd.emit && cmd.load_final)

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Sprite scanline evaluation: pointer access to the sprite memory and
// per-line sprite selection under mixes of tall sprites, rendering and
// the eight-per-line limit. A shadow of the memory, pointer and settings
// predicts every result word, which is checked field by field in order.
// ============================================================================
module testbench;

  localparam int PER_LINE      = 8;
  localparam int SPRITE_TOTAL  = 64;
  localparam int SETTLE_CYCLES = 140;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk;
  logic rst_n;
  bit   steady;
  int   failures;
  int   cycles;

  sse_chan_if #(.T(sse_pkg::item_t))   item_if ();
  sse_chan_if #(.T(sse_pkg::result_t)) result_if ();
  sse_chan_if #(.T(sse_pkg::cfg_t))    cfg_if ();

  sprite_scanline_evaluation dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  logic [7:0]       oam_shadow [256];
  logic [7:0]       oam_ptr;
  bit               tall_mode;
  bit               render_on;
  bit               limit_on;
  sse_pkg::result_t pending_results [$];
  sse_pkg::result_t got_word;
  sse_pkg::result_t want_word;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_if.ready = steady || ($urandom_range(99) >= 22);
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && result_if.valid && result_if.ready) begin
      got_word = result_if.payload;
      if (pending_results.size() == 0) begin
        $error("result word with no expectation");
        failures++;
      end else begin
        want_word = pending_results.pop_front();
        check_field("read_data", want_word.read_data, got_word.read_data);
        check_field("sprite_valid", 8'(want_word.sprite_valid), 8'(got_word.sprite_valid));
        check_field("sprite_number", 8'(want_word.sprite_number),
                    8'(got_word.sprite_number));
        check_field("sprite_ypos", want_word.sprite_ypos, got_word.sprite_ypos);
        check_field("sprite_tile", want_word.sprite_tile, got_word.sprite_tile);
        check_field("sprite_attr", want_word.sprite_attr, got_word.sprite_attr);
        check_field("sprite_xpos", want_word.sprite_xpos, got_word.sprite_xpos);
        check_field("overflow", 8'(want_word.overflow), 8'(got_word.overflow));
        check_field("zero_in_range", 8'(want_word.zero_in_range),
                    8'(got_word.zero_in_range));
        check_field("last", 8'(want_word.last), 8'(got_word.last));
      end
    end
  end

  // sprite words are held back one step so the flags land on the final one
  function automatic void evaluate_line(logic [8:0] line);
    int               scan_line;
    int               height;
    int               row_off;
    int               cap;
    int               emitted;
    int               i;
    bit               ovf;
    bit               zero;
    bit               have_held;
    sse_pkg::result_t held;
    scan_line = (line == sse_pkg::PRERENDER_LINE) ? -1 : int'(line);
    height    = tall_mode ? 16 : 8;
    cap       = limit_on ? PER_LINE : SPRITE_TOTAL;
    emitted   = 0;
    ovf       = 1'b0;
    zero      = 1'b0;
    have_held = 1'b0;
    held      = '0;
    for (i = 0; i < SPRITE_TOTAL; i++) begin
      row_off = scan_line - int'(oam_shadow[i*4]);
      if (row_off >= 0 && row_off < height) begin
        if (i == 0) zero = 1'b1;
        if (emitted == PER_LINE && render_on) ovf = 1'b1;
        if (emitted == PER_LINE && limit_on) break;
        if (emitted < cap) begin
          if (have_held) pending_results.push_back(held);
          held               = '0;
          held.sprite_valid  = 1'b1;
          held.sprite_number = i[5:0];
          held.sprite_ypos   = oam_shadow[i*4];
          held.sprite_tile   = oam_shadow[i*4+1];
          held.sprite_attr   = oam_shadow[i*4+2];
          held.sprite_xpos   = oam_shadow[i*4+3];
          have_held          = 1'b1;
          emitted++;
        end
      end
    end
    held.overflow      = ovf;
    held.zero_in_range = zero;
    held.last          = 1'b1;
    pending_results.push_back(held);
  endfunction

  function automatic void predict_item(sse_pkg::item_t word);
    sse_pkg::result_t r;
    case (word.func)
      sse_pkg::FUNC_SET: begin
        oam_ptr = word.value;
      end
      sse_pkg::FUNC_WRITE: begin
        oam_shadow[oam_ptr] = word.value;
        oam_ptr++;
      end
      sse_pkg::FUNC_READ: begin
        r           = '0;
        r.read_data = oam_shadow[oam_ptr];
        r.last      = 1'b1;
        pending_results.push_back(r);
      end
      default: begin
        evaluate_line(word.line);
      end
    endcase
  endfunction

  task automatic send_item(sse_pkg::func_e f, logic [7:0] value, logic [8:0] line);
    sse_pkg::item_t word;
    word.func  = f;
    word.value = value;
    word.line  = line;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 22) begin
      item_if.valid = 1'b0;
      @(negedge clk);
    end
    item_if.valid   = 1'b1;
    item_if.payload = word;
    do @(posedge clk); while (!item_if.ready);
    predict_item(word);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [1:0] index, bit data);
    sse_pkg::cfg_t word;
    word.index = index;
    word.data  = data;
    @(negedge clk);
    item_if.valid = 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_if.valid   = 1'b1;
    cfg_if.payload = word;
    do @(posedge clk); while (!cfg_if.ready);
    case (index)
      sse_pkg::CFG_TALL:      tall_mode = data;
      sse_pkg::CFG_RENDERING: render_on = data;
      sse_pkg::CFG_LIMIT:     limit_on  = data;
      default:                ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_setting(bit tall, bit render, bit limit);
    configure(sse_pkg::CFG_TALL, tall);
    configure(sse_pkg::CFG_RENDERING, render);
    configure(sse_pkg::CFG_LIMIT, limit);
  endtask

  // all sprites sit at y 0xff after reset
  task automatic test_reset_contents();
    send_item(sse_pkg::FUNC_READ, 8'h00, 9'd0);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'd255);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, sse_pkg::PRERENDER_LINE);
    send_item(sse_pkg::FUNC_EVAL, 8'hff, 9'd511);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'd262);
  endtask

  task automatic test_pointer_wrap();
    send_item(sse_pkg::FUNC_SET, 8'hff, 9'd0);
    send_item(sse_pkg::FUNC_WRITE, 8'h00, 9'd0);
    send_item(sse_pkg::FUNC_WRITE, 8'h10, 9'd0);
    send_item(sse_pkg::FUNC_READ, 8'h00, 9'd0);
    send_item(sse_pkg::FUNC_SET, 8'h00, 9'd0);
    send_item(sse_pkg::FUNC_READ, 8'h00, 9'd0);
  endtask

  task automatic test_line_window();
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'h010);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'h017);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'h018);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'd0);
  endtask

  task automatic test_overflow_rules();
    configure(sse_pkg::CFG_RENDERING, 1'b1);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'd255);
    configure(sse_pkg::CFG_LIMIT, 1'b0);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'd255);
    configure(sse_pkg::CFG_TALL, 1'b1);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'h01f);
    send_item(sse_pkg::FUNC_EVAL, 8'h00, 9'd270);
  endtask

  // bursts of sprite bytes clustered near one line, then lines over them
  task automatic test_random_traffic(int budget, int base_line);
    int         sent;
    int         focus;
    int         burst;
    int         k;
    int         evals;
    logic [7:0] start;
    logic [7:0] data;
    logic [8:0] line;
    sent = 0;
    while (sent < budget) begin
      focus = base_line + $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0: begin
          send_item(sse_pkg::func_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    9'($urandom_range(0, 511)));
          sent++;
        end
        1: begin
          send_item(sse_pkg::FUNC_SET, 8'($urandom_range(0, 255)),
                    9'($urandom_range(0, 511)));
          send_item(sse_pkg::FUNC_READ, 8'($urandom_range(0, 255)),
                    9'($urandom_range(0, 511)));
          sent += 2;
        end
        default: begin
          if ($urandom_range(0, 4) == 0) start = 8'($urandom_range(0, 255));
          else start = 8'($urandom_range(0, 63) * 4);
          send_item(sse_pkg::FUNC_SET, start, 9'($urandom_range(0, 511)));
          burst = $urandom_range(4, 16);
          for (k = 0; k < burst; k++) begin
            if (((start + k) & 3) == 0) data = 8'(focus - $urandom_range(0, 17));
            else data = 8'($urandom_range(0, 255));
            send_item(sse_pkg::FUNC_WRITE, data, 9'($urandom_range(0, 511)));
          end
          evals = $urandom_range(1, 3);
          for (k = 0; k < evals; k++) begin
            case ($urandom_range(0, 7))
              0:       line = sse_pkg::PRERENDER_LINE;
              1:       line = 9'($urandom_range(0, 511));
              default: line = 9'(focus + $urandom_range(0, 3));
            endcase
            send_item(sse_pkg::FUNC_EVAL, 8'($urandom_range(0, 255)), line);
          end
          sent += 1 + burst + evals;
        end
      endcase
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    steady          = 1'b0;
    failures        = 0;
    cycles          = 0;
    item_if.valid   = 1'b0;
    item_if.payload = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    result_if.ready = 1'b0;
    for (int i = 0; i < 256; i++) oam_shadow[i] = 8'hff;
    oam_ptr   = 8'h00;
    tall_mode = 1'b0;
    render_on = 1'b0;
    limit_on  = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_contents();
    test_pointer_wrap();
    test_line_window();
    test_overflow_rules();

    apply_setting(1'b1, 1'b1, 1'b1);
    test_random_traffic(45, 100);
    apply_setting(1'b0, 1'b0, 1'b0);
    test_random_traffic(40, 30);
    apply_setting(1'b0, 1'b1, 1'b1);
    steady = 1'b1;
    test_random_traffic(40, 200);
    steady = 1'b0;
    apply_setting(1'b1, 1'b0, 1'b1);
    test_random_traffic(45, 245);

    @(negedge clk);
    item_if.valid = 1'b0;
    wait_drained();
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
